FILE: sv/line_start_offset_indexer_macros.svh
// assertion helpers for the checker file
`ifndef LINE_START_OFFSET_INDEXER_MACROS_SVH
`define LINE_START_OFFSET_INDEXER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LSOI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LSOI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lsoi_pkg.sv
package lsoi_pkg;

    // fixed widths of the input item fields
    localparam int DATA_BITS  = 64;
    localparam int VALID_BITS = 4;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // one-bit scanner state carried between items
    typedef struct packed {
        logic cr_pending;
        logic first_sent;
        logic saturated;
    } lsoi_flags_t;

endpackage

FILE: sv/lsoi_scan.sv
module lsoi_scan #(
    parameter int BYTES_PER_ITEM = 8
) (
    input  logic [lsoi_pkg::DATA_BITS-1:0]              data,
    input  logic [lsoi_pkg::VALID_BITS-1:0]             valid_bytes,
    input  logic                                        cr_pending_in,
    output logic [$clog2(BYTES_PER_ITEM+1)-1:0]         byte_count,
    output logic [BYTES_PER_ITEM-1:0]                   emit_mask,
    output logic [BYTES_PER_ITEM-1:0]                   lf_mask,
    output logic                                        cr_after
);
    import lsoi_pkg::*;

    localparam int CNT_W      = $clog2(BYTES_PER_ITEM + 1);
    localparam int EXT_BYTES  = (BYTES_PER_ITEM > DATA_BITS / 8) ? BYTES_PER_ITEM
                                                                 : DATA_BITS / 8;

    logic [8*EXT_BYTES-1:0] data_ext;
    logic [7:0]             cur_byte;
    logic                   prev_cr;
    logic                   is_lf;

    // bytes past the data word read as zero
    assign data_ext = (8*EXT_BYTES)'(data);

    // clamp the count to the item width
    always_comb
    begin
        if (int'(valid_bytes) > BYTES_PER_ITEM)
        begin
            byte_count = CNT_W'(BYTES_PER_ITEM);
        end
        else
        begin
            byte_count = CNT_W'(valid_bytes);
        end
    end

    // a byte is marked when it is LF (the line starts after it), or when it follows a
    // CR that it does not complete as CR LF (the line starts at it)
    always_comb
    begin
        prev_cr   = cr_pending_in;
        cr_after  = cr_pending_in;
        emit_mask = '0;
        lf_mask   = '0;
        cur_byte  = '0;
        is_lf     = 1'b0;
        for (int j = 0; j < BYTES_PER_ITEM; j++)
        begin
            if (j < int'(byte_count))
            begin
                cur_byte     = data_ext[8*j +: 8];
                is_lf        = (cur_byte == CHAR_LF);
                emit_mask[j] = is_lf || prev_cr;
                lf_mask[j]   = is_lf;
                prev_cr      = (cur_byte == CHAR_CR);
                cr_after     = prev_cr;
            end
        end
    end

endmodule

FILE: sv/line_start_offset_indexer.sv
// Line start offset indexer. Text arrives BYTES_PER_ITEM bytes per item, lowest
// address first, with a count of valid bytes and an end-of-buffer flag; the block
// returns the byte offset of every line start, beginning with 0. LF, a lone CR and
// CR LF each end a line, and the offset given is the one just after the break; a
// CR in the last byte of an item waits for the next byte or for the end flag. The
// position counter saturates at all ones and the overflow flag stays set until the
// end of the buffer. Each offset comes with last_of_run high on the final offset
// caused by its item. The path is three registers deep: an input register, an
// event register that holds the line starts found in one item, and a result
// register; an item's offsets pass from the input register through the event
// register to the result register. Items causing zero or one line start stream
// at one per cycle while out_ready is high; an item causing k line starts (at
// most BYTES_PER_ITEM + 1) stays in the event register while the result
// register sends one offset per cycle whenever out_ready allows.
module line_start_offset_indexer #(
    parameter int BYTES_PER_ITEM = 8,
    parameter int OFFSET_BITS    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input item channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lsoi_pkg::DATA_BITS-1:0]    data,
    input  logic [lsoi_pkg::VALID_BITS-1:0]   valid_bytes,
    input  logic                              end_of_buffer,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [OFFSET_BITS-1:0]            line_offset,
    output logic                              last_of_run,
    output logic                              overflow
);
    import lsoi_pkg::*;

    localparam int CNT_W  = $clog2(BYTES_PER_ITEM + 1);
    // slot 0 is the offset-zero start, slots 1..N the bytes, top slot the end flush
    localparam int SLOT_W = BYTES_PER_ITEM + 2;
    localparam logic [OFFSET_BITS-1:0] MAX_POS = {OFFSET_BITS{1'b1}};

    // input register
    logic                  a_valid_reg;
    logic [DATA_BITS-1:0]  a_data_reg;
    logic [VALID_BITS-1:0] a_valid_bytes_reg;
    logic                  a_eob_reg;

    // scanner state
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    lsoi_flags_t            flags_reg;
    lsoi_flags_t            flags_next;

    // event register: pending line starts of one item
    logic [SLOT_W-1:0]      b_mask_reg;
    logic [SLOT_W-1:0]      b_mask_next;
    logic [SLOT_W-1:0]      b_lf_reg;
    logic [CNT_W-1:0]       b_count_reg;
    logic [OFFSET_BITS-1:0] b_base_reg;
    logic                   b_sat_reg;

    // result register
    logic                   out_valid_reg;
    logic [OFFSET_BITS-1:0] line_offset_reg;
    logic                   last_reg;
    logic                   overflow_reg;

    // scan outputs
    logic [CNT_W-1:0]          byte_count;
    logic [BYTES_PER_ITEM-1:0] emit_mask;
    logic [BYTES_PER_ITEM-1:0] lf_mask;
    logic                      cr_after;

    logic [OFFSET_BITS:0]   adv_sum;
    logic                   flush;
    logic [SLOT_W-1:0]      event_mask;

    logic [SLOT_W-1:0]      sel_hot;
    logic [CNT_W-1:0]       sel_steps;
    logic [SLOT_W-1:0]      remain_mask;
    logic                   sel_last;
    logic [OFFSET_BITS:0]   emit_sum;
    logic [OFFSET_BITS-1:0] emit_offset;
    logic                   emit_ovf;

    logic b_has;
    logic out_load;
    logic b_free;
    logic process_item;
    logic in_take;

    lsoi_scan #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_lsoi_scan (
        .data          (a_data_reg),
        .valid_bytes   (a_valid_bytes_reg),
        .cr_pending_in (flags_reg.cr_pending),
        .byte_count    (byte_count),
        .emit_mask     (emit_mask),
        .lf_mask       (lf_mask),
        .cr_after      (cr_after)
    );

    // handshake: the event register frees when its last start moves to the result
    assign b_has        = |b_mask_reg;
    assign out_load     = b_has && (!out_valid_reg || out_ready);
    assign b_free       = !b_has || (out_load && sel_last);
    assign process_item = a_valid_reg && b_free;
    assign in_ready     = !a_valid_reg || b_free;
    assign in_take      = in_valid && in_ready;

    // position after this item's bytes, saturating; carry means it went past the top
    assign adv_sum    = {1'b0, pos_reg} + (OFFSET_BITS+1)'(byte_count);
    assign flush      = a_eob_reg && cr_after;
    assign event_mask = {flush, emit_mask, !flags_reg.first_sent};

    // state update; the end flag returns everything to the reset state
    always_comb
    begin
        if (a_eob_reg)
        begin
            pos_next   = '0;
            flags_next = '0;
        end
        else
        begin
            pos_next              = adv_sum[OFFSET_BITS] ? MAX_POS : adv_sum[OFFSET_BITS-1:0];
            flags_next.saturated  = flags_reg.saturated | adv_sum[OFFSET_BITS];
            flags_next.cr_pending = cr_after;
            flags_next.first_sent = 1'b1;
        end
    end

    // pick the lowest pending start and the number of bytes consumed before it
    // (a CR start comes before its byte, an LF start after it)
    always_comb
    begin
        sel_hot   = '0;
        sel_steps = '0;
        for (int s = SLOT_W - 1; s >= 0; s--)
        begin
            if (b_mask_reg[s])
            begin
                sel_hot = SLOT_W'(1) << s;
                if (s == 0)
                begin
                    sel_steps = '0;
                end
                else if (s == SLOT_W - 1)
                begin
                    sel_steps = b_count_reg;
                end
                else
                begin
                    sel_steps = CNT_W'(s - 1 + int'(b_lf_reg[s]));
                end
            end
        end
    end

    assign remain_mask = b_mask_reg & ~sel_hot;
    assign sel_last    = (remain_mask == '0);

    // offset = base + steps with saturation; overflow if base was saturated
    // or the steps ran past the top
    assign emit_sum    = {1'b0, b_base_reg} + (OFFSET_BITS+1)'(sel_steps);
    assign emit_offset = emit_sum[OFFSET_BITS] ? MAX_POS : emit_sum[OFFSET_BITS-1:0];
    assign emit_ovf    = b_sat_reg | emit_sum[OFFSET_BITS];

    always_comb
    begin
        if (process_item)
        begin
            b_mask_next = event_mask;
        end
        else if (out_load)
        begin
            b_mask_next = remain_mask;
        end
        else
        begin
            b_mask_next = b_mask_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            pos_reg       <= '0;
            flags_reg     <= '0;
            b_mask_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (process_item)
            begin
                a_valid_reg <= 1'b0;
            end

            if (process_item)
            begin
                pos_reg   <= pos_next;
                flags_reg <= flags_next;
            end

            b_mask_reg <= b_mask_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_data_reg        <= data;
            a_valid_bytes_reg <= valid_bytes;
            a_eob_reg         <= end_of_buffer;
        end
        if (process_item)
        begin
            b_lf_reg    <= {1'b0, lf_mask, 1'b0};
            b_count_reg <= byte_count;
            b_base_reg  <= pos_reg;
            b_sat_reg   <= flags_reg.saturated;
        end
        if (out_load)
        begin
            line_offset_reg <= emit_offset;
            last_reg        <= sel_last;
            overflow_reg    <= emit_ovf;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_offset = line_offset_reg;
    assign last_of_run = last_reg;
    assign overflow    = overflow_reg;

endmodule

FILE: sv/lsoi_checker.sv
module lsoi_checker #(
    parameter int OFFSET_BITS = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [OFFSET_BITS-1:0] line_offset,
    input logic                   last_of_run,
    input logic                   overflow
);

`include "line_start_offset_indexer_macros.svh"

    // a stalled result holds its item
    `LSOI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(line_offset) && $stable(last_of_run) && $stable(overflow), "result changed while stalled")

    // a saturated counter only ever reports the top offset
    `LSOI_ASSERT_IMPLY(a_ovf_max, clk, rst_n, out_valid && overflow, &line_offset, "overflow with offset below maximum")

    // within one item's run the next offset follows at once and stays saturated
    `LSOI_ASSERT_NEXT(a_ovf_sticky, clk, rst_n, out_valid && out_ready && overflow && !last_of_run, out_valid && overflow, "overflow dropped within a run")

    // nothing leaves right after reset
    `LSOI_ASSERT_IMPLY(a_reset_quiet, clk, rst_n, $rose(rst_n), !out_valid, "result present right after reset")

endmodule

bind line_start_offset_indexer lsoi_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_lsoi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .line_offset (line_offset),
    .last_of_run (last_of_run),
    .overflow    (overflow)
);

FILE: verif/tb_line_start_offset_indexer.sv
`timescale 1ns / 100ps

module tb_line_start_offset_indexer;

    import lsoi_pkg::*;

    // one expected line start as the block should report it
    typedef struct {
        logic [31:0] offset;
        logic        last;
        logic        ovf;
    } line_start_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [DATA_BITS-1:0]  data = '0;
    logic [VALID_BITS-1:0] valid_bytes = '0;
    logic                  end_of_buffer = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic [31:0]           line_offset;
    logic                  last_of_run;
    logic                  overflow;

    // predictor state, mirrors the scanner between items
    logic [31:0] scan_pos;
    logic        scan_cr_pending;
    logic        scan_first_sent;
    logic        scan_saturated;

    line_start_t expected_line_starts[$];
    int          error_count;
    bit          feed_idle_on;
    bit          ready_stall_on;
    int          stall_left;

    line_start_offset_indexer #(
        .BYTES_PER_ITEM(8),
        .OFFSET_BITS   (32)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data         (data),
        .valid_bytes  (valid_bytes),
        .end_of_buffer(end_of_buffer),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_offset  (line_offset),
        .last_of_run  (last_of_run),
        .overflow     (overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard limit, far above the slowest legal run
    initial
    begin
        #3000000;
        $display("line_start_offset_indexer verification failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // line start predictor
    // ---------------------------------------------------------------------

    function automatic void clear_scan_state();
        scan_pos        = '0;
        scan_cr_pending = 1'b0;
        scan_first_sent = 1'b0;
        scan_saturated  = 1'b0;
    endfunction

    function automatic void push_line_start(logic [31:0] offset);
        line_start_t e;
        e.offset = offset;
        e.last   = 1'b0;
        e.ovf    = scan_saturated;
        expected_line_starts = {expected_line_starts, e};
    endfunction

    // counter holds at all ones; trying to step past it sets the sticky flag
    function automatic void step_position();
        if (scan_pos == 32'hFFFF_FFFF)
            scan_saturated = 1'b1;
        else
            scan_pos = scan_pos + 32'd1;
    endfunction

    function automatic void predict_line_starts(logic [63:0] d, logic [3:0] vb, logic eob);
        int          n_bytes;
        int          n_found;
        logic [7:0]  b;
        logic        was_cr;
        n_bytes = (vb > 4'd8) ? 8 : int'(vb);
        n_found = 0;
        // every buffer opens with offset 0, even an item with no bytes
        if (!scan_first_sent)
        begin
            push_line_start(32'd0);
            scan_first_sent = 1'b1;
            n_found++;
        end
        for (int k = 0; k < n_bytes; k++)
        begin
            b = d[8*k +: 8];
            was_cr = scan_cr_pending;
            scan_cr_pending = 1'b0;
            // lone cr: the line starts before this byte is counted
            if (was_cr && b != CHAR_LF)
            begin
                push_line_start(scan_pos);
                n_found++;
            end
            step_position();
            if (b == CHAR_LF)
            begin
                push_line_start(scan_pos);
                n_found++;
            end
            else if (b == CHAR_CR)
                scan_cr_pending = 1'b1;
        end
        // end of buffer flushes a trailing cr and starts over
        if (eob)
        begin
            if (scan_cr_pending)
            begin
                push_line_start(scan_pos);
                n_found++;
            end
            clear_scan_state();
        end
        if (n_found > 0)
            expected_line_starts[$].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // result checking, sampled at the clock edge
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin
        line_start_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_line_starts.size() == 0)
            begin
                $error("unexpected line start: line_offset %0d", line_offset);
                error_count++;
            end
            else
            begin
                e = expected_line_starts.pop_front();
                if (line_offset !== e.offset)
                begin
                    $error("line_offset expected %0d actual %0d", e.offset, line_offset);
                    error_count++;
                end
                if (last_of_run !== e.last)
                begin
                    $error("last_of_run expected %0b actual %0b", e.last, last_of_run);
                    error_count++;
                end
                if (overflow !== e.ovf)
                begin
                    $error("overflow expected %0b actual %0b", e.ovf, overflow);
                    error_count++;
                end
            end
        end
    end

    // receiver back-pressure: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (ready_stall_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------

    // called at a clock edge; returns at the edge where the item is taken
    task automatic send_item(input logic [63:0] d, input logic [3:0] vb, input logic eob);
        int gap;
        gap = 0;
        if (feed_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data          <= d;
        valid_bytes   <= vb;
        end_of_buffer <= eob;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_line_starts(d, vb, eob);
    endtask

    // mostly printable text with breaks, plus bytes that trip a word-wide filter
    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 9)
            return CHAR_LF;
        else if (r < 16)
            return CHAR_CR;
        else if (r < 22)
            return 8'h80 | (CHAR_LF ^ 8'(($urandom_range(0, 1)) ? 8'h07 : 8'h00));
        else if (r < 30)
            return 8'($urandom_range(0, 255));
        else
            return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // random buffers of 1 to 12 items; mostly full words, the tail item of random length
    task automatic send_random_text(input int item_total);
        int          sent;
        int          buf_len;
        int          r;
        logic [63:0] d;
        logic [3:0]  vb;
        logic        eob;
        sent = 0;
        while (sent < item_total)
        begin
            buf_len = $urandom_range(1, 12);
            for (int k = 0; k < buf_len && sent < item_total; k++)
            begin
                eob = (k == buf_len - 1) || (sent == item_total - 1);
                // a few items are pure noise
                if ($urandom_range(0, 99) < 8)
                    d = {$urandom, $urandom};
                else
                    for (int j = 0; j < 8; j++)
                        d[8*j +: 8] = random_text_byte();
                r = $urandom_range(0, 99);
                if (r < 4)
                    vb = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
                else if (r < 20 || eob)
                    vb = 4'($urandom_range(1, 8));
                else
                    vb = 4'd8;
                send_item(d, vb, eob);
                sent++;
            end
        end
    endtask

    // hand-picked items: breaks of every kind, short and odd valid counts
    task automatic test_directed_cases();
        send_item(64'h0000_0000_0000_0000, 4'd1, 1'b1);   // lone offset 0, then reset
        send_item(64'h0A0A_0A0A_0A0A_0A0A, 4'd8, 1'b0);   // fresh buffer, all lf: 9 starts
        send_item(64'h6564_0D63_620A_0D61, 4'd8, 1'b0);   // cr lf pair and a lone cr
        send_item(64'h0D41_4141_4141_4141, 4'd8, 1'b0);   // cr held at the item edge
        send_item(64'h4141_4141_4141_410A, 4'd8, 1'b0);   // ... joined by lf
        send_item(64'hFFFF_FFFF_FFFF_FF0D, 4'd1, 1'b0);   // cr held, junk beyond count
        send_item(64'h0A0A_0A0A_0A0A_0A42, 4'd1, 1'b0);   // ... resolved by non-lf
        send_item(64'h0D0D_0D0D_0D0D_0D0D, 4'd8, 1'b1);   // cr run, last one flushed
        send_item(64'h0A0A_0A0A_0A0A_0A0A, 4'd0, 1'b0);   // no bytes, still offset 0
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
        send_item(64'h0000_0000_0000_000D, 4'd1, 1'b0);
        send_item(64'h0000_0000_0000_000A, 4'd0, 1'b1);   // empty end item flushes cr
        send_item(64'h0000_0000_0000_0000, 4'd0, 1'b1);   // empty buffer
        send_item(64'h0A0A_0A0A_0A0A_0A0A, 4'd9, 1'b0);   // count clamped to 8
        send_item(64'h0D0A_0D0A_0D0A_0D0A, 4'd15, 1'b1);
        send_item(64'h0D7A_7A7A_7A7A_7A7A, 4'd8, 1'b1);   // cr in last byte with end
        send_item(64'h8E8E_8A8D_7A0B_0C09, 4'd8, 1'b1);   // near misses only
        send_item(64'h0A0D_4141_4141_4141, 4'd7, 1'b0);   // cr last valid, lf beyond
        send_item(64'h0000_0000_0000_0000, 4'd8, 1'b1);
    endtask

    // sender holds off until every expected line start has come back
    task automatic test_drain_pause();
        send_random_text(4);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_line_starts.size() != 0)
            @(posedge clk);
        send_random_text(6);
    endtask

    task automatic test_random_text();
        send_random_text(300);
    endtask

    // back to back at full rate, no idling on either side
    task automatic test_full_rate();
        feed_idle_on   = 1'b0;
        ready_stall_on = 1'b0;
        send_random_text(60);
    endtask

    initial
    begin
        clear_scan_state();
        error_count    = 0;
        stall_left     = 0;
        feed_idle_on   = 1'b1;
        ready_stall_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_drain_pause();
        test_random_text();
        test_full_rate();

        in_valid <= 1'b0;
        while (expected_line_starts.size() != 0)
            @(posedge clk);
        // catch any stray result from a trailing item
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("line_start_offset_indexer verification clean");
        else
            $display("line_start_offset_indexer verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/lsoi_pkg.sv
sv/lsoi_scan.sv
sv/line_start_offset_indexer.sv
sv/lsoi_checker.sv
verif/tb_line_start_offset_indexer.sv
